// ===== src/bst_pkg.sv =====
`default_nettype none

package bst_pkg;

   // Token kinds as they appear on the result channel.
   localparam logic [3:0] KIND_ID     = 4'd0;
   localparam logic [3:0] KIND_INT    = 4'd1;
   localparam logic [3:0] KIND_HYPHEN = 4'd2;
   localparam logic [3:0] KIND_ARROW  = 4'd3;
   localparam logic [3:0] KIND_EQUALS = 4'd4;
   localparam logic [3:0] KIND_LPAREN = 4'd5;
   localparam logic [3:0] KIND_RPAREN = 4'd6;
   localparam logic [3:0] KIND_LBRACE = 4'd7;
   localparam logic [3:0] KIND_RBRACE = 4'd8;
   localparam logic [3:0] KIND_COLON  = 4'd9;
   localparam logic [3:0] KIND_COMMA  = 4'd10;
   localparam logic [3:0] KIND_LT     = 4'd11;
   localparam logic [3:0] KIND_GT     = 4'd12;
   localparam logic [3:0] KIND_SEMI   = 4'd13;
   localparam logic [3:0] KIND_EOF    = 4'd14;
   localparam logic [3:0] KIND_ERROR  = 4'd15;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] text_byte;
      logic       token_end;
      logic       last;
   } result_type;

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

endpackage

`default_nettype wire

// ===== src/byte_stream_tokenizer_core.sv =====
`default_nettype none

// Byte stream tokenizer. One source byte is taken per item and turned into tokens, one result
// per character, the last character of each token flagged by rsp_token_end. Letter and digit
// runs and a hyphen are held back one byte, so a token's final character comes out when the
// byte after it arrives; a zero byte flushes it and gives end-of-file. The decode runs in the
// accepting cycle and its results are written into a small result queue. While rsp_ready is
// high, the queue drains one result per cycle and a byte that causes at most one result is
// taken every cycle, while a byte that causes two (an arrow, or a flushed token followed by
// another result) takes two queue entries. req_ready is high while the queue has room for two
// results. After an unknown byte the block reports an error and then takes and discards every
// byte until reset.
module byte_stream_tokenizer_core #(
   parameter int QueueDepth = bst_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_kind,
   output logic [7:0]      rsp_text_byte,
   output logic            rsp_token_end,
   output logic            rsp_last
);
   import bst_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ID,
      MODE_INT,
      MODE_HYPHEN,
      MODE_DEAD
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic [7:0]           held_ff, held_in;
   result_type           queue_ff [QueueDepth];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]  count_ff, count_in;

   logic                 accept, pop;
   logic [1:0]           n_res;
   result_type           res0, res1;

   assign accept = req_valid && req_ready;
   assign pop    = rsp_valid && rsp_ready;

   always_comb begin
      logic [7:0] b;
      logic       done;
      logic       cont;
      logic [3:0] run_kind;
      logic       sec_valid;
      result_type sec;
      b         = req_in_byte;
      done      = 1'b0;
      cont      = 1'b0;
      run_kind  = KIND_ID;
      sec_valid = 1'b0;
      sec       = '0;
      n_res     = 2'd0;
      res0      = '0;
      res1      = '0;
      mode_in   = mode_ff;
      held_in   = held_ff;

      // First part: settle whatever is held from the previous byte.
      unique case (mode_ff)
         MODE_ID, MODE_INT: begin
            cont     = (mode_ff == MODE_ID) ? is_letter(b) : is_digit(b);
            run_kind = (mode_ff == MODE_ID) ? KIND_ID : KIND_INT;
            res0     = '{kind: run_kind, text_byte: held_ff, token_end: !cont, last: 1'b0};
            n_res    = 2'd1;
            if (cont) begin
               held_in = b;
               done    = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
               held_in = CHAR_NUL;
            end
         end
         MODE_HYPHEN: begin
            if (b == CHAR_GT) begin
               res0  = '{kind: KIND_ARROW, text_byte: CHAR_HYPHEN, token_end: 1'b0, last: 1'b0};
               res1  = '{kind: KIND_ARROW, text_byte: CHAR_GT, token_end: 1'b1, last: 1'b0};
               n_res = 2'd2;
               done  = 1'b1;
            end else begin
               res0  = '{kind: KIND_HYPHEN, text_byte: CHAR_HYPHEN, token_end: 1'b1,
                         last: 1'b0};
               n_res = 2'd1;
            end
            mode_in = MODE_IDLE;
            held_in = CHAR_NUL;
         end
         MODE_DEAD: begin
            done = 1'b1;
         end
         default: begin
         end
      endcase

      // Second part: the new byte itself.
      if (!done) begin
         sec_valid = 1'b1;
         sec       = '{kind: KIND_ERROR, text_byte: b, token_end: 1'b1, last: 1'b0};
         case (b) inside
            CHAR_NUL: begin
               sec     = '{kind: KIND_EOF, text_byte: CHAR_NUL, token_end: 1'b1, last: 1'b0};
               mode_in = MODE_IDLE;
               held_in = CHAR_NUL;
            end
            CHAR_CR, CHAR_LF, CHAR_SPACE, CHAR_TAB: sec_valid = 1'b0;
            CHAR_HYPHEN: begin
               sec_valid = 1'b0;
               mode_in   = MODE_HYPHEN;
               held_in   = b;
            end
            CHAR_EQUALS:              sec.kind = KIND_EQUALS;
            CHAR_LPAREN:              sec.kind = KIND_LPAREN;
            CHAR_RPAREN:              sec.kind = KIND_RPAREN;
            CHAR_LBRACE, CHAR_LBRACK: sec.kind = KIND_LBRACE;
            CHAR_RBRACE, CHAR_RBRACK: sec.kind = KIND_RBRACE;
            CHAR_COLON:               sec.kind = KIND_COLON;
            CHAR_COMMA:               sec.kind = KIND_COMMA;
            CHAR_LT:                  sec.kind = KIND_LT;
            CHAR_GT:                  sec.kind = KIND_GT;
            CHAR_SEMI:                sec.kind = KIND_SEMI;
            default: begin
               if (is_letter(b)) begin
                  sec_valid = 1'b0;
                  mode_in   = MODE_ID;
                  held_in   = b;
               end else if (is_digit(b)) begin
                  sec_valid = 1'b0;
                  mode_in   = MODE_INT;
                  held_in   = b;
               end else begin
                  mode_in = MODE_DEAD;
                  held_in = CHAR_NUL;
               end
            end
         endcase
         if (sec_valid) begin
            if (n_res == 2'd0) begin
               res0 = sec;
            end else begin
               res1 = sec;
            end
            n_res = n_res + 2'd1;
         end
      end

      // The final result caused by this byte carries the last flag.
      if (n_res == 2'd1) begin
         res0.last = 1'b1;
      end
      if (n_res == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + PtrWidth'(n_res);
         count_in  = count_in + CntWidth'(n_res);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PtrWidth'(1);
         count_in  = count_in - CntWidth'(1);
      end
   end

   assign req_ready     = count_ff <= CntWidth'(QueueDepth - 2);
   assign rsp_valid     = count_ff != '0;
   assign rsp_kind      = queue_ff[rd_ptr_ff].kind;
   assign rsp_text_byte = queue_ff[rd_ptr_ff].text_byte;
   assign rsp_token_end = queue_ff[rd_ptr_ff].token_end;
   assign rsp_last      = queue_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         held_ff   <= CHAR_NUL;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            held_ff <= held_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (accept && n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrWidth'(1)] <= res1;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(QueueDepth))
      else $error("result queue holds more items than it has entries");

   a_dead_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DEAD |=> mode_ff == MODE_DEAD)
      else $error("tokenizer left the error state without reset");

   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_DEAD) |-> n_res == 2'd0)
      else $error("result produced after an error");

   a_hyphen_held: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HYPHEN |-> held_ff == CHAR_HYPHEN)
      else $error("hyphen mode without a held hyphen");

endmodule

`default_nettype wire
